### sv/ktmp_pkg.sv
// Package for the k-trade max profit stream unit.
// Holds field widths, default sizes and width helper functions.
// Used by ktmp_cell and k_trade_max_profit_stream_unit.
package ktmp_pkg;

	localparam int MAX_K_DEF      = 16;
	localparam int PRICE_BITS_DEF = 16;
	localparam int PRICE_FIELD_W  = 16;
	localparam int PROFIT_FIELD_W = 20;
	localparam int OUT_DATA_W     = 24;
	localparam int TRADES_W       = 5;
	localparam logic [TRADES_W-1:0] TRADES_RESET = 5'd1;

	// profit of level j is at most (j+1) * max price
	function automatic int prof_w(input int max_k, input int price_bits);
		return price_bits + $clog2(max_k) + 1;
	endfunction

	// signed cost: holds the cleared value 2^(PRICE_BITS+5)-1 and -max profit
	function automatic int cost_w(input int max_k, input int price_bits);
		return price_bits + $clog2(max_k) + 7;
	endfunction

	function automatic int lvl_w(input int max_k);
		return (max_k > 1) ? $clog2(max_k) : 1;
	endfunction

endpackage

### sv/ktmp_cell.sv
// One trade-level cell: lowest effective cost and best profit of its level.
// Registers the transaction and hands it to the next level each cycle that adv is high.
// Depends on ktmp_pkg.
module ktmp_cell import ktmp_pkg::*; #(
	parameter int MAX_K      = MAX_K_DEF,
	parameter int PRICE_BITS = PRICE_BITS_DEF,
	parameter int IDX        = 0
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   adv,
	input  logic [lvl_w(MAX_K)-1:0]                sel,
	input  logic                                   in_valid,
	input  logic                                   in_start,
	input  logic [PRICE_BITS-1:0]                  in_price,
	input  logic [prof_w(MAX_K, PRICE_BITS)-1:0]   in_prev,
	input  logic [prof_w(MAX_K, PRICE_BITS)-1:0]   in_pick,
	output logic                                   out_valid_q,
	output logic                                   out_start_q,
	output logic [PRICE_BITS-1:0]                  out_price_q,
	output logic [prof_w(MAX_K, PRICE_BITS)-1:0]   out_prev_q,
	output logic [prof_w(MAX_K, PRICE_BITS)-1:0]   out_pick_q
);

	localparam int PROF_W = prof_w(MAX_K, PRICE_BITS);
	localparam int COST_W = cost_w(MAX_K, PRICE_BITS);
	localparam int LVL_W  = lvl_w(MAX_K);
	localparam logic signed [COST_W-1:0] COST_RESET =
		COST_W'((64'd1 << (PRICE_BITS + 5)) - 64'd1);

	logic signed [COST_W-1:0] cost_q;
	logic        [PROF_W-1:0] profit_q;
	logic signed [COST_W-1:0] cost_cur;
	logic        [PROF_W-1:0] prof_cur;
	logic signed [COST_W-1:0] p_s;
	logic signed [COST_W-1:0] prev_s;
	logic signed [COST_W-1:0] c_s;
	logic signed [COST_W-1:0] cost_nxt;
	logic signed [COST_W-1:0] gain_s;
	logic        [PROF_W-1:0] prof_nxt;

	always_comb begin
		cost_cur = in_start ? COST_RESET : cost_q;
		prof_cur = in_start ? '0 : profit_q;
		p_s      = signed'(COST_W'(in_price));
		prev_s   = signed'(COST_W'(in_prev));
		c_s      = p_s - prev_s;
		cost_nxt = (c_s < cost_cur) ? c_s : cost_cur;
		gain_s   = p_s - cost_nxt;
		prof_nxt = (gain_s > signed'(COST_W'(prof_cur))) ? PROF_W'(gain_s) : prof_cur;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cost_q      <= COST_RESET;
			profit_q    <= '0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= in_valid;
			if (in_valid) begin
				cost_q   <= cost_nxt;
				profit_q <= prof_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_start_q <= in_start;
			out_price_q <= in_price;
			out_prev_q  <= prof_nxt;
			out_pick_q  <= (sel == LVL_W'(IDX)) ? prof_nxt : in_pick;
		end
	end

endmodule

### sv/k_trade_max_profit_stream_unit.sv
// Streaming best profit with at most k buy-sell trades: top level.
// A chain of MAX_K ktmp_cell levels; the last level registers the result.
// Depends on ktmp_pkg and ktmp_cell.
//
//  channel  | signals                           | content
//  ---------+-----------------------------------+------------------------------
//  input    | s_tvalid s_tready s_tdata s_tuser | tdata[15:0] price, tuser[0] start_req
//  output   | m_tvalid m_tready m_tdata         | tdata[19:0] best_profit
//  config   | cfg_we cfg_wdata                  | max_trades (k)
//
// A transaction moves one trade level per cycle while the chain advances.
// One transaction per cycle is accepted while the output is free or taken.
// A stall on the output holds the whole chain; s_tready drops with it.
// Reset clears every level (cost to its top value, profit to zero), k to 1.
module k_trade_max_profit_stream_unit import ktmp_pkg::*; #(
	parameter int MAX_K      = MAX_K_DEF,
	parameter int PRICE_BITS = PRICE_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [PRICE_FIELD_W-1:0]  s_tdata,   // [15:0] price
	input  logic                      s_tuser,   // [0] start_req
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [OUT_DATA_W-1:0]     m_tdata,   // [19:0] best_profit, rest zero
	input  logic                      cfg_we,
	input  logic [TRADES_W-1:0]       cfg_wdata
);

	localparam int PROF_W = prof_w(MAX_K, PRICE_BITS);
	localparam int LVL_W  = lvl_w(MAX_K);

	logic [TRADES_W-1:0] max_trades_q;
	logic [LVL_W-1:0]    sel;
	logic                adv;

	logic [MAX_K:0]          lk_valid;
	logic [MAX_K:0]          lk_start;
	logic [PRICE_BITS-1:0]   lk_price [MAX_K+1];
	logic [PROF_W-1:0]       lk_prev  [MAX_K+1];
	logic [PROF_W-1:0]       lk_pick  [MAX_K+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_trades_q <= TRADES_RESET;
		end else if (cfg_we) begin
			max_trades_q <= cfg_wdata;
		end
	end

	always_comb begin
		if (max_trades_q == '0) begin
			sel = '0;
		end else if (32'(max_trades_q) > MAX_K) begin
			sel = LVL_W'(MAX_K - 1);
		end else begin
			sel = LVL_W'(32'(max_trades_q) - 32'd1);
		end
	end

	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;

	assign lk_valid[0] = s_tvalid;
	assign lk_start[0] = s_tuser;
	assign lk_price[0] = PRICE_BITS'(s_tdata);
	assign lk_prev[0]  = '0;
	assign lk_pick[0]  = '0;

	for (genvar j = 0; j < MAX_K; j++) begin : g_lvl
		ktmp_cell #(
			.MAX_K      (MAX_K),
			.PRICE_BITS (PRICE_BITS),
			.IDX        (j)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.adv         (adv),
			.sel         (sel),
			.in_valid    (lk_valid[j]),
			.in_start    (lk_start[j]),
			.in_price    (lk_price[j]),
			.in_prev     (lk_prev[j]),
			.in_pick     (lk_pick[j]),
			.out_valid_q (lk_valid[j+1]),
			.out_start_q (lk_start[j+1]),
			.out_price_q (lk_price[j+1]),
			.out_prev_q  (lk_prev[j+1]),
			.out_pick_q  (lk_pick[j+1])
		);
	end

	assign m_tvalid = lk_valid[MAX_K];
	assign m_tdata  = OUT_DATA_W'(PROFIT_FIELD_W'(lk_pick[MAX_K]));

endmodule
